// ===== rtl/bus_command_servo_switch_controller_unit_defines.svh =====
// Assertion macros shared by the bcssc RTL.
`ifndef BUS_COMMAND_SERVO_SWITCH_CONTROLLER_UNIT_DEFINES_SVH
`define BUS_COMMAND_SERVO_SWITCH_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define BCSSC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define BCSSC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bcssc_pkg.sv =====
package bcssc_pkg;

    localparam int BUFFER_LIMIT   = 16;
    localparam int SERVO_CHANNELS = 6;
    localparam int HELD_BYTES     = 3;
    localparam int REPLY_LIMIT    = 5;
    localparam int REPLY_ONE_POS  = 1;
    localparam int OUT_SERVOS     = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CNT_W  = $clog2(BUFFER_LIMIT + 1);
    localparam int HOLD_W = $clog2(HELD_BYTES);
    localparam int RP_W   = $clog2(REPLY_LIMIT + 1);
    localparam int CHAN_W = (SERVO_CHANNELS > 1) ? $clog2(SERVO_CHANNELS) : 1;
    localparam int SW_W   = 11;

    // servo compare = value * 41 / 255 + 39
    localparam int SERVO_MUL   = 41;
    localparam int SERVO_DIV   = 255;
    localparam int SERVO_OFS   = 39;
    localparam int SERVO_RESET = 59;
    localparam int LED_CHAN    = 1;   // command 2
    localparam int X_W = 22;          // 16-bit value times 41
    localparam int P_W = X_W + 8;     // x * 257
    localparam int Q_W = P_W - 16;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_SERVO,
        ACT_SWITCH
    } act_kind_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] servo1_compare;
        logic [7:0] servo2_compare;
        logic [7:0] servo3_compare;
        logic [7:0] servo4_compare;
        logic [7:0] servo5_compare;
        logic [7:0] servo6_compare;
        logic [5:0] port_c_drive;
        logic [2:0] port_b_drive;
        logic [1:0] port_a_drive;
        logic       led_state;
    } out_item_t;

    // Classified transaction handed from front to back.
    typedef struct packed {
        logic              rd_one;
        act_kind_t         kind;
        logic [CHAN_W-1:0] chan;
        logic [15:0]       value;
    } cmd_entry_t;

endpackage

// ===== rtl/bcssc_front.sv =====
`include "bus_command_servo_switch_controller_unit_defines.svh"

module bcssc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bcssc_pkg::in_item_t   in_item,
    input  logic                  q_full,
    output logic                  push,
    output bcssc_pkg::cmd_entry_t push_entry
);
    import bcssc_pkg::*;

    logic [7:0]       cmd_reg [HELD_BYTES];
    logic [7:0]       cmd_next [HELD_BYTES];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RP_W-1:0]  rp_reg, rp_next;
    logic             idle_reg, idle_next;
    logic [7:0]       cmd_m1;
    cmd_entry_t       entry;

    assign in_stall   = q_full;
    assign push       = in_valid && !q_full;
    assign push_entry = entry;

    always_comb
    begin
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        rp_next      = rp_reg;
        idle_next    = idle_reg;
        cmd_m1       = cmd_reg[0] - 8'd1;
        entry.rd_one = 1'b0;
        entry.kind   = ACT_NONE;
        entry.chan   = cmd_m1[CHAN_W-1:0];
        entry.value  = {cmd_reg[1], cmd_reg[2]};
        unique case (in_item.opcode)
            OP_START:
            begin
                // start is ignored while a transaction is open
                if (idle_reg)
                begin
                    for (int k = 0; k < HELD_BYTES; k++)
                    begin
                        cmd_next[k] = 8'd0;
                    end
                    cnt_next  = '0;
                    rp_next   = '0;
                    idle_next = 1'b0;
                end
            end
            OP_WRITE:
            begin
                if (cnt_reg < CNT_W'(HELD_BYTES))
                begin
                    cmd_next[cnt_reg[HOLD_W-1:0]] = in_item.data_byte;
                end
                if (cnt_reg < CNT_W'(BUFFER_LIMIT))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (rp_reg < RP_W'(REPLY_LIMIT))
                begin
                    entry.rd_one = (rp_reg == RP_W'(REPLY_ONE_POS));
                    rp_next      = rp_reg + RP_W'(1);
                end
            end
            OP_STOP:
            begin
                if (cnt_reg > CNT_W'(1))
                begin
                    if (cmd_reg[0] == 8'd0)
                    begin
                        entry.kind = ACT_SWITCH;
                    end
                    else if (cmd_reg[0] <= 8'(SERVO_CHANNELS))
                    begin
                        entry.kind = ACT_SERVO;
                    end
                end
                idle_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HELD_BYTES; k++)
            begin
                cmd_reg[k] <= 8'd0;
            end
            cnt_reg  <= '0;
            rp_reg   <= '0;
            idle_reg <= 1'b1;
        end
        else if (push)
        begin
            cmd_reg  <= cmd_next;
            cnt_reg  <= cnt_next;
            rp_reg   <= rp_next;
            idle_reg <= idle_next;
        end
    end

    `BCSSC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(BUFFER_LIMIT), "byte count past limit")
    `BCSSC_ASSERT_NXT(a_start_clear, clk, rst_n, push && in_item.opcode == OP_START && idle_reg, cnt_reg == '0 && rp_reg == '0 && !idle_reg, "start did not open transaction")

endmodule

// ===== rtl/bcssc_queue.sv =====
`include "bus_command_servo_switch_controller_unit_defines.svh"

module bcssc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bcssc_pkg::cmd_entry_t push_entry,
    output logic                  full,
    output logic                  q_valid,
    input  logic                  pop,
    output bcssc_pkg::cmd_entry_t q_entry
);
    import bcssc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    cmd_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [QC_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == QC_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QC_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

    `BCSSC_ASSERT_NXT(a_pop_drains, clk, rst_n, pop && !push, count_reg == $past(count_reg) - QC_W'(1), "pop did not drain queue")
    `BCSSC_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, q_valid, "pop from empty queue")

endmodule

// ===== rtl/bcssc_back.sv =====
`include "bus_command_servo_switch_controller_unit_defines.svh"

module bcssc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  bcssc_pkg::cmd_entry_t q_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bcssc_pkg::out_item_t  out_item
);
    import bcssc_pkg::*;

    // stage A: value * 41
    logic              a_valid_reg;
    logic              a_rd_reg;
    act_kind_t         a_kind_reg;
    logic [CHAN_W-1:0] a_chan_reg;
    logic [SW_W-1:0]   a_sw_reg;
    logic [X_W-1:0]    a_x_reg;

    // stage B: divide by 255, apply, output register
    logic              out_valid_reg;
    out_item_t         out_reg, out_next;
    logic [7:0]        servo_reg [SERVO_CHANNELS];
    logic [7:0]        servo_next [SERVO_CHANNELS];
    logic [SW_W-1:0]   sw_reg, sw_next;
    logic              led_reg, led_next;

    logic              b_ready, a_ready, b_fire;
    logic [P_W-1:0]    prod;
    logic [Q_W-1:0]    q0, quo;
    logic [X_W-1:0]    rem;
    logic [7:0]        comp;
    logic [7:0]        servo_view [OUT_SERVOS];

    assign b_ready   = !out_valid_reg || !out_stall;
    assign a_ready   = !a_valid_reg || b_ready;
    assign pop       = q_valid && a_ready;
    assign b_fire    = a_valid_reg && b_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_rd_reg   <= q_entry.rd_one;
            a_kind_reg <= q_entry.kind;
            a_chan_reg <= q_entry.chan;
            a_sw_reg   <= q_entry.value[SW_W-1:0];
            a_x_reg    <= X_W'(q_entry.value) * X_W'(SERVO_MUL);
        end
    end

    // x / 255: x*257 >> 16 is low by at most one, one correction step
    always_comb
    begin
        prod = (P_W'(a_x_reg) << 8) + P_W'(a_x_reg);
        q0   = prod[P_W-1:16];
        rem  = a_x_reg - (X_W'(q0) << 8) + X_W'(q0);
        quo  = (rem >= X_W'(SERVO_DIV)) ? q0 + Q_W'(1) : q0;
        comp = quo[7:0] + 8'(SERVO_OFS);
    end

    always_comb
    begin
        servo_next = servo_reg;
        sw_next    = sw_reg;
        led_next   = led_reg;
        case (a_kind_reg)
            ACT_SERVO:
            begin
                servo_next[a_chan_reg] = comp;
                if (a_chan_reg == CHAN_W'(LED_CHAN))
                begin
                    led_next = !led_reg;
                end
            end
            ACT_SWITCH:
            begin
                sw_next = a_sw_reg;
            end
            default:
            begin
            end
        endcase

        for (int k = 0; k < OUT_SERVOS; k++)
        begin
            servo_view[k] = 8'd0;
            if (k < SERVO_CHANNELS)
            begin
                servo_view[k] = servo_next[k];
            end
        end

        out_next.read_data      = {7'd0, a_rd_reg};
        out_next.servo1_compare = servo_view[0];
        out_next.servo2_compare = servo_view[1];
        out_next.servo3_compare = servo_view[2];
        out_next.servo4_compare = servo_view[3];
        out_next.servo5_compare = servo_view[4];
        out_next.servo6_compare = servo_view[5];
        out_next.port_c_drive   = {sw_next[0], sw_next[1], sw_next[2],
                                   sw_next[3], sw_next[4], sw_next[5]};
        out_next.port_b_drive   = {sw_next[6], sw_next[7], sw_next[8]};
        out_next.port_a_drive   = {sw_next[9], sw_next[10]};
        out_next.led_state      = led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SERVO_CHANNELS; k++)
            begin
                servo_reg[k] <= 8'(SERVO_RESET);
            end
            sw_reg  <= '0;
            led_reg <= 1'b0;
        end
        else if (b_fire)
        begin
            out_valid_reg <= 1'b1;
            servo_reg     <= servo_next;
            sw_reg        <= sw_next;
            led_reg       <= led_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            out_reg <= out_next;
        end
    end

    `BCSSC_ASSERT_IMP(a_rem_fixed, clk, rst_n, a_valid_reg, rem < X_W'(2 * SERVO_DIV), "divide correction out of range")
    `BCSSC_ASSERT_NXT(a_led_toggle, clk, rst_n, b_fire && a_kind_reg == ACT_SERVO && a_chan_reg == CHAN_W'(LED_CHAN), led_reg != $past(led_reg), "led did not toggle")

endmodule

// ===== rtl/bus_command_servo_switch_controller_unit.sv =====
// Channel   Direction  Payload      Handshake
// in        input      in_item_t    in_valid / in_stall   (one bus event)
// out       output     out_item_t   out_valid / out_stall (state after event)
//
// One transaction in per cycle when nothing stalls, one result out per transaction.
// The front updates bus state in the accept cycle and pushes the entry into
// the queue; the back then runs stage A on value*41 and stage B on the /255,
// the register update and the output register.
// Reset: control state cleared, servo compares to 59, bus stopped (data regs not reset).
// A stalled output backs up the back pipe, then the 2-entry queue, then in_stall.
module bus_command_servo_switch_controller_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bcssc_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bcssc_pkg::out_item_t out_item
);
    import bcssc_pkg::*;

    logic       push;
    logic       q_full;
    logic       q_valid;
    logic       pop;
    cmd_entry_t push_entry;
    cmd_entry_t q_entry;

    // Front: tracks start/stop, the three command bytes, byte count and
    // read pointer; turns a stop with a valid command into a servo or switch action.
    bcssc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Short queue decouples front from back.
    bcssc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .pop        (pop),
        .q_entry    (q_entry)
    );

    // Back: computes the compare value, holds servo, switch and led state,
    // and owns the output register.
    bcssc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
